// ===== rtl/websocket_frame_deframer_core_macros.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/wsd_pkg.sv =====
// Types, constants and helpers for the WebSocket deframer.
`default_nettype none
package wsd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [16:0] MAX_PAYLOAD_RST = 17'h10000;
  localparam logic [6:0]  LEN_CODE16      = 7'd126;
  localparam logic [6:0]  LEN_CODE64      = 7'd127;
  localparam logic [3:0]  OP_CLOSE        = 4'h8;
  localparam logic [3:0]  OP_PING         = 4'h9;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT_HI,
    PH_EXT_LO,
    PH_MASK,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_t;

  typedef enum logic [1:0] {
    ACT_IGNORE = 2'd0,
    ACT_PONG   = 2'd1,
    ACT_CLOSE  = 2'd2,
    ACT_DROP   = 2'd3
  } act_t;

  // One classified result word: the back end applies the key byte.
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  raw_byte;
    logic [7:0]  key_byte;
    logic [15:0] byte_index;
    logic [3:0]  frame_opcode;
    logic        frame_end;
    act_t        action;
  } item_t;

  function automatic act_t end_action(input logic [3:0] opcode);
    act_t act;
    act = ACT_IGNORE;
    if (opcode == OP_CLOSE) begin
      act = ACT_CLOSE;
    end else if (opcode == OP_PING) begin
      act = ACT_PONG;
    end
    return act;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wsd_front.sv =====
// Header parser: walks the frame header and tags each payload byte.
`default_nettype none
`include "websocket_frame_deframer_core_macros.svh"
module wsd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  input  wire logic [16:0]    cfg_max_payload,
  input  wire logic           byte_take,
  input  wire logic [7:0]     rx_byte,
  output wsd_pkg::item_t      q_item,
  output logic                q_push
);

  wsd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic [16:0] max_r;

  logic [15:0] len_v;
  logic        chk, start, drop;
  wsd_pkg::act_t act_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= wsd_pkg::PH_HDR0;
      opcode_r <= '0;
      masked_r <= 1'b0;
      len_r    <= '0;
      seen_r   <= '0;
      key_r    <= '0;
      kidx_r   <= '0;
      max_r    <= wsd_pkg::MAX_PAYLOAD_RST;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      seen_r   <= seen_nxt;
      key_r    <= key_nxt;
      kidx_r   <= kidx_nxt;
      if (cfg_valid) begin
        max_r <= cfg_max_payload;
      end
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    seen_nxt   = seen_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    len_v      = len_r;
    chk        = 1'b0;
    start      = 1'b0;
    drop       = 1'b0;
    act_v      = wsd_pkg::end_action(opcode_r);
    q_push     = 1'b0;
    q_item              = '0;
    q_item.frame_opcode = opcode_r;

    if (byte_take) begin
      unique case (phase_r)
        wsd_pkg::PH_HDR0: begin
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = wsd_pkg::PH_HDR1;
        end
        wsd_pkg::PH_HDR1: begin
          masked_nxt = rx_byte[7];
          if (rx_byte[6:0] == wsd_pkg::LEN_CODE64) begin
            drop = 1'b1;
          end else if (rx_byte[6:0] == wsd_pkg::LEN_CODE16) begin
            len_nxt   = '0;
            phase_nxt = wsd_pkg::PH_EXT_HI;
          end else begin
            len_v   = {9'd0, rx_byte[6:0]};
            len_nxt = len_v;
            chk     = 1'b1;
          end
        end
        wsd_pkg::PH_EXT_HI: begin
          len_nxt   = {rx_byte, 8'h00};
          phase_nxt = wsd_pkg::PH_EXT_LO;
        end
        wsd_pkg::PH_EXT_LO: begin
          len_v   = {len_r[15:8], rx_byte};
          len_nxt = len_v;
          chk     = 1'b1;
        end
        wsd_pkg::PH_MASK: begin
          key_nxt[{kidx_r, 3'b000} +: 8] = rx_byte;
          if (kidx_r == 2'd3) begin
            start = 1'b1;
          end else begin
            kidx_nxt = kidx_r + 2'd1;
          end
        end
        wsd_pkg::PH_PAYLOAD: begin
          q_push            = 1'b1;
          q_item.has_byte   = 1'b1;
          q_item.raw_byte   = rx_byte;
          q_item.key_byte   = key_r[{seen_r[1:0], 3'b000} +: 8];
          q_item.byte_index = seen_r;
          if (({1'b0, seen_r} + 17'd1) >= {1'b0, len_r}) begin
            q_item.frame_end = 1'b1;
            q_item.action    = act_v;
            phase_nxt = (act_v == wsd_pkg::ACT_CLOSE) ? wsd_pkg::PH_STOPPED
                                                      : wsd_pkg::PH_HDR0;
            seen_nxt  = '0;
          end else begin
            seen_nxt = seen_r + 16'd1;
          end
        end
        wsd_pkg::PH_STOPPED: begin
        end
        default: begin
        end
      endcase
    end

    // length just became known: limit check, then key, payload or an empty-frame end
    if (chk) begin
      if ({1'b0, len_v} > max_r) begin
        drop = 1'b1;
      end else begin
        key_nxt  = '0;
        kidx_nxt = '0;
        if (masked_nxt) begin
          phase_nxt = wsd_pkg::PH_MASK;
        end else begin
          start = 1'b1;
        end
      end
    end

    if (start) begin
      seen_nxt = '0;
      if (len_v == 16'd0) begin
        q_push           = 1'b1;
        q_item.frame_end = 1'b1;
        q_item.action    = act_v;
        phase_nxt = (act_v == wsd_pkg::ACT_CLOSE) ? wsd_pkg::PH_STOPPED
                                                  : wsd_pkg::PH_HDR0;
      end else begin
        phase_nxt = wsd_pkg::PH_PAYLOAD;
      end
    end

    if (drop) begin
      q_push           = 1'b1;
      q_item.frame_end = 1'b1;
      q_item.action    = wsd_pkg::ACT_DROP;
      phase_nxt        = wsd_pkg::PH_STOPPED;
    end
  end

  `WSD_ASSERT_NEXT(a_stop_sticks, clk, rst_n, phase_r == wsd_pkg::PH_STOPPED,
    phase_r == wsd_pkg::PH_STOPPED, "stopped parser resumed")

endmodule
`default_nettype wire

// ===== rtl/wsd_queue.sv =====
// Short word queue between the parser and the output stage.
`default_nettype none
`include "websocket_frame_deframer_core_macros.svh"
module wsd_queue #(
  parameter int unsigned DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wsd_pkg::item_t      wr_item,
  output logic                full,
  input  wire logic           pop,
  output wsd_pkg::item_t      rd_item,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wsd_pkg::item_t     mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  `WSD_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `WSD_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty, "pop from empty queue")
  `WSD_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop,
    count_r == $past(count_r) + CNT_W'(1), "queue count lost a push")

endmodule
`default_nettype wire

// ===== rtl/wsd_back.sv =====
// Output stage: unmasks the queued word and holds it for the receiver.
`default_nettype none
module wsd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wsd_pkg::item_t      q_item,
  output logic                q_pop,
  input  wire logic           out_pop,
  output logic                out_empty,
  output logic                out_has_byte,
  output logic [7:0]          out_payload_byte,
  output logic [15:0]         out_byte_index,
  output logic [3:0]          out_frame_opcode,
  output logic                out_frame_end,
  output logic [1:0]          out_action
);

  logic        valid_r;
  logic        has_r;
  logic [7:0]  data_r;
  logic [15:0] index_r;
  logic [3:0]  opcode_r;
  logic        end_r;
  logic [1:0]  action_r;

  assign q_pop = !q_empty && (!valid_r || out_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      has_r    <= q_item.has_byte;
      data_r   <= q_item.raw_byte ^ q_item.key_byte;
      index_r  <= q_item.byte_index;
      opcode_r <= q_item.frame_opcode;
      end_r    <= q_item.frame_end;
      action_r <= 2'(q_item.action);
    end
  end

  assign out_empty        = !valid_r;
  assign out_has_byte     = has_r;
  assign out_payload_byte = data_r;
  assign out_byte_index   = index_r;
  assign out_frame_opcode = opcode_r;
  assign out_frame_end    = end_r;
  assign out_action       = action_r;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_deframer_core.sv =====
// Top level of the client-to-server WebSocket frame deframer.
//
// Input: one received byte per word on in_rx_byte, taken when in_push is high
// and in_full is low. Header bytes (two fixed, optional 16-bit length, optional
// 4-byte mask key) yield only the end word of an empty or dropped frame; each
// payload byte makes one result. Output: results wait in order; the oldest is on
// out_* while out_empty is low and leaves when out_pop is high. frame_end marks
// the last word of a frame; action is 0 ignore, 1 pong, 2 close (then stopped),
// 3 dropped. A 64-bit length or a length above max_payload gives a drop word,
// then every further byte is discarded until reset. Config: cfg_max_payload is
// written on cfg_valid (cfg_ready is always high); the user must write it only
// while no word is in flight (not enforced). Reset value is 65536 (no limit).
// Timing: one byte per cycle while in_full is low; each result passes the queue
// and the output register before it shows. The parser updates its header state
// as each byte is taken; a QUEUE_DEPTH-word queue and an output register behind
// it absorb a stalled receiver until the queue fills, then in_full rises.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to
// the first header byte.
`default_nettype none
module websocket_frame_deframer_core #(
  parameter int unsigned QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_max_payload,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_has_byte,
  output logic [7:0]       out_payload_byte,
  output logic [15:0]      out_byte_index,
  output logic [3:0]       out_frame_opcode,
  output logic             out_frame_end,
  output logic [1:0]       out_action
);

  wsd_pkg::item_t push_item, head_item;
  logic           q_push, q_full, q_pop, q_empty;
  logic           byte_take;

  // config is always accepted; the parser latches it directly
  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign byte_take = in_push && !q_full;

  wsd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_max_payload (cfg_max_payload),
    .byte_take       (byte_take),
    .rx_byte         (in_rx_byte),
    .q_item          (push_item),
    .q_push          (q_push)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (push_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (head_item),
    .empty   (q_empty)
  );

  wsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_item           (head_item),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_has_byte     (out_has_byte),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_end    (out_frame_end),
    .out_action       (out_action)
  );

endmodule
`default_nettype wire

// ===== verif/deframer_checker.sv =====
// Checker for the WebSocket deframer: predicts each result word and compares it.
`timescale 1ns / 1ps
module deframer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_max_payload,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic        out_has_byte,
  input  logic [7:0]  out_payload_byte,
  input  logic [15:0] out_byte_index,
  input  logic [3:0]  out_frame_opcode,
  input  logic        out_frame_end,
  input  logic [1:0]  out_action,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic           has_byte;
    logic [7:0]     data;
    logic [15:0]    index;
    logic [3:0]     opcode;
    logic           last;
    wsd_pkg::act_t  action;
  } deframed_t;

  deframed_t        frame_results_q[$];
  wsd_pkg::phase_t  phase;
  logic [3:0]       opcode;
  logic             masked;
  logic [15:0]      length;
  logic [15:0]      seen;
  logic [31:0]      key;
  logic [1:0]       key_pos;
  logic [16:0]      limit;
  int               reports;

  function automatic wsd_pkg::act_t action_for(input logic [3:0] op);
    case (op)
      wsd_pkg::OP_CLOSE: return wsd_pkg::ACT_CLOSE;
      wsd_pkg::OP_PING:  return wsd_pkg::ACT_PONG;
      default:           return wsd_pkg::ACT_IGNORE;
    endcase
  endfunction

  task automatic expect_result(input logic has, input logic [7:0] data, input logic [15:0] idx,
                               input logic last, input wsd_pkg::act_t act);
    deframed_t r;
    r.has_byte = has;
    r.data     = data;
    r.index    = idx;
    r.opcode   = opcode;
    r.last     = last;
    r.action   = act;
    frame_results_q.push_back(r);
  endtask

  task automatic drop_connection();
    expect_result(1'b0, 8'h00, 16'h0000, 1'b1, wsd_pkg::ACT_DROP);
    phase = wsd_pkg::PH_STOPPED;
  endtask

  // header fully in: either an empty frame ends here or payload follows
  task automatic header_done();
    wsd_pkg::act_t act;
    seen = '0;
    if (length == 16'h0000) begin
      act = action_for(opcode);
      expect_result(1'b0, 8'h00, 16'h0000, 1'b1, act);
      phase = (act == wsd_pkg::ACT_CLOSE) ? wsd_pkg::PH_STOPPED : wsd_pkg::PH_HDR0;
    end else begin
      phase = wsd_pkg::PH_PAYLOAD;
    end
  endtask

  // limit is checked before any mask key byte
  task automatic length_done();
    if ({1'b0, length} > limit) begin
      drop_connection();
    end else begin
      key     = '0;
      key_pos = '0;
      if (masked) begin
        phase = wsd_pkg::PH_MASK;
      end else begin
        header_done();
      end
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0]    data;
    wsd_pkg::act_t act;
    case (phase)
      wsd_pkg::PH_HDR0: begin
        opcode = b[3:0];
        phase  = wsd_pkg::PH_HDR1;
      end
      wsd_pkg::PH_HDR1: begin
        masked = b[7];
        if (b[6:0] == wsd_pkg::LEN_CODE64) begin
          drop_connection();
        end else if (b[6:0] == wsd_pkg::LEN_CODE16) begin
          length = '0;
          phase  = wsd_pkg::PH_EXT_HI;
        end else begin
          length = {9'd0, b[6:0]};
          length_done();
        end
      end
      wsd_pkg::PH_EXT_HI: begin
        length = {b, 8'h00};
        phase  = wsd_pkg::PH_EXT_LO;
      end
      wsd_pkg::PH_EXT_LO: begin
        length[7:0] = b;
        length_done();
      end
      wsd_pkg::PH_MASK: begin
        key[8*key_pos +: 8] = b;
        if (key_pos == 2'd3) begin
          header_done();
        end else begin
          key_pos++;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        data = masked ? (b ^ key[8*seen[1:0] +: 8]) : b;
        if ({1'b0, seen} + 17'd1 >= {1'b0, length}) begin
          act = action_for(opcode);
          expect_result(1'b1, data, seen, 1'b1, act);
          phase = (act == wsd_pkg::ACT_CLOSE) ? wsd_pkg::PH_STOPPED : wsd_pkg::PH_HDR0;
          seen  = '0;
        end else begin
          expect_result(1'b1, data, seen, 1'b0, wsd_pkg::ACT_IGNORE);
          seen++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    deframed_t exp_r;
    if (!rst_n) begin
      frame_results_q.delete();
      phase   = wsd_pkg::PH_HDR0;
      opcode  = '0;
      masked  = 1'b0;
      length  = '0;
      seen    = '0;
      key     = '0;
      key_pos = '0;
      limit   = wsd_pkg::MAX_PAYLOAD_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit = cfg_max_payload;
      end
      if (in_push && !in_full) begin
        deframe_byte(in_rx_byte);
      end
      if (out_pop && !out_empty) begin
        results_checked++;
        if (frame_results_q.size() == 0) begin
          fail_count++;
          if (reports < MAX_REPORTS) begin
            $display("unexpected word: has=%0d byte=%02h idx=%0d op=%h end=%0d act=%0d",
                     out_has_byte, out_payload_byte, out_byte_index, out_frame_opcode,
                     out_frame_end, out_action);
          end
          reports++;
        end else begin
          exp_r = frame_results_q.pop_front();
          if (exp_r.has_byte !== out_has_byte || exp_r.data !== out_payload_byte ||
              exp_r.index !== out_byte_index || exp_r.opcode !== out_frame_opcode ||
              exp_r.last !== out_frame_end || exp_r.action !== out_action) begin
            fail_count++;
            if (reports < MAX_REPORTS) begin
              $display("mismatch at %0t: expected has=%0d byte=%02h idx=%0d op=%h end=%0d act=%0d",
                       $realtime, exp_r.has_byte, exp_r.data, exp_r.index, exp_r.opcode,
                       exp_r.last, exp_r.action);
              $display("                 got has=%0d byte=%02h idx=%0d op=%h end=%0d act=%0d",
                       out_has_byte, out_payload_byte, out_byte_index, out_frame_opcode,
                       out_frame_end, out_action);
            end
            reports++;
          end
        end
      end
    end
    pending = frame_results_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Top of the deframer testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps
module tb;

  // Flag nibble and opcodes used to build first header bytes.
  localparam logic [3:0] FIN_ONLY    = 4'h8;
  localparam logic [3:0] RSV_NO_FIN  = 4'h7;
  localparam logic [3:0] OP_CONT     = 4'h0;
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_BINARY   = 4'h2;
  localparam logic [3:0] OP_PONG     = 4'hA;
  localparam logic [3:0] OP_RESERVED = 4'hF;

  // A correct run ends well within CYCLE_LIMIT, even with the slowest receiver.
  localparam int CYCLE_LIMIT  = 40000;
  // Results pass queue and output register; header bytes leave nothing to wait on.
  localparam int DRAIN_CYCLES = 8;

  // Ways the connection gets stopped at the end of the run.
  typedef enum {
    STOP_CLOSE_EMPTY,
    STOP_CLOSE_DATA,
    STOP_LEN64,
    STOP_OVER_LIMIT
  } stop_kind_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic [16:0] cfg_max_payload = '0;
  logic        in_push         = 1'b0;
  logic [7:0]  in_rx_byte      = '0;
  logic        out_pop         = 1'b0;

  logic        cfg_ready;
  logic        in_full;
  logic        out_empty;
  logic        out_has_byte;
  logic [7:0]  out_payload_byte;
  logic [15:0] out_byte_index;
  logic [3:0]  out_frame_opcode;
  logic        out_frame_end;
  logic [1:0]  out_action;

  int          fail_count;
  int          pending;
  int          results_checked;

  // Idle percentages of sender and receiver, changed per phase.
  int          send_idle = 11;
  int          recv_idle = 59;
  int          words_sent;
  int          frames_sent;
  int          cycles;
  logic [16:0] payload_cap = wsd_pkg::MAX_PAYLOAD_RST;  // stimulus copy of max_payload
  stop_kind_t  stop_kind;
  logic [7:0]  stop_hdr;

  websocket_frame_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_payload  (cfg_max_payload),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_has_byte     (out_has_byte),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_end    (out_frame_end),
    .out_action       (out_action)
  );

  deframer_checker frame_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_max_payload  (cfg_max_payload),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_has_byte     (out_has_byte),
    .out_payload_byte (out_payload_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_end    (out_frame_end),
    .out_action       (out_action),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stalls at random, one decision per cycle on the falling edge.
  always @(negedge clk) begin
    out_pop = ($urandom_range(99) >= recv_idle);
  end

  // One word into the input queue. Push stays high across back-to-back words;
  // in_full is read right after the rising edge, i.e. the value the DUT saw.
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push    = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    @(negedge clk);
    words_sent++;
  endtask

  // Client frame: header, optional 16-bit length, optional key, payload.
  // fill < 0 gives random payload bytes, otherwise every byte is fill.
  task automatic send_frame(input logic [7:0] hdr0, input bit masked, input int len,
                            input bit use_ext, input logic [31:0] key, input int fill);
    frames_sent++;
    send_word(hdr0);
    if (use_ext || len > 125) begin
      send_word({masked, wsd_pkg::LEN_CODE16});
      send_word(len[15:8]);
      send_word(len[7:0]);
    end else begin
      send_word({masked, len[6:0]});
    end
    if (masked) begin
      for (int k = 0; k < 4; k++) begin
        send_word(key[8*k +: 8]);
      end
    end
    for (int i = 0; i < len; i++) begin
      send_word((fill < 0) ? 8'($urandom) : fill[7:0]);
    end
  endtask

  // Random well-formed frames within the current limit, never a close.
  // Lengths stay short mostly; sometimes zero, min(cap, 300), or the 7-bit maximum.
  task automatic send_random_frames(input int budget);
    int          stop_at;
    int          top;
    int          len;
    int          pick;
    logic [7:0]  hdr0;
    logic [31:0] key;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      top  = (payload_cap < 300) ? int'(payload_cap) : 300;
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = 0;
      end else if (pick < 20) begin
        len = top;
      end else if (pick < 23) begin
        len = (top < 125) ? top : 125;
      end else if (pick < 40) begin
        len = $urandom_range(top);
      end else begin
        len = $urandom_range((top < 24) ? top : 24);
      end
      hdr0 = 8'($urandom);
      if (hdr0[3:0] == wsd_pkg::OP_CLOSE || $urandom_range(6) == 0) begin
        hdr0[3:0] = wsd_pkg::OP_PING;
      end
      pick = $urandom_range(9);
      key  = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      send_frame(hdr0, $urandom_range(99) < 70, len, $urandom_range(9) == 0, key, -1);
    end
  endtask

  // Drain: every expected word out, then let the pipeline settle.
  task automatic wait_idle();
    in_push = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_payload(input logic [16:0] value);
    cfg_valid       = 1'b1;
    cfg_max_payload = value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid   = 1'b0;
    payload_cap = value;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty frame, masked empty ping, RSV bits with 0xFF payload,
    // all-ones key over zero bytes, short length carried in the 16-bit field.
    write_max_payload(wsd_pkg::MAX_PAYLOAD_RST);
    send_frame({FIN_ONLY, OP_CONT}, 1'b0, 0, 1'b0, 32'h0000_0000, -1);
    send_frame({FIN_ONLY, wsd_pkg::OP_PING}, 1'b1, 0, 1'b0, 32'hFFFF_FFFF, -1);
    send_frame({RSV_NO_FIN, OP_RESERVED}, 1'b0, 1, 1'b0, 32'h0000_0000, 8'hFF);
    send_frame({FIN_ONLY, OP_PONG}, 1'b1, 2, 1'b0, 32'hFFFF_FFFF, 8'h00);
    send_frame({FIN_ONLY, OP_TEXT}, 1'b0, 3, 1'b1, 32'h0000_0000, -1);
    wait_idle();

    // Zero limit: only empty frames pass (length equal to the limit is fine).
    write_max_payload(17'd0);
    send_random_frames(40);
    wait_idle();

    write_max_payload(17'($urandom_range(300, 1)));
    send_random_frames(200);
    wait_idle();

    // Receiver mostly ready, sender slow.
    send_idle = 59;
    recv_idle = 11;
    write_max_payload(17'($urandom_range(65535, 301)));
    send_random_frames(200);
    wait_idle();

    // Full rate: one masked frame right at the limit, then random traffic.
    send_idle = 0;
    recv_idle = 0;
    write_max_payload(17'd160);
    send_frame({FIN_ONLY, OP_BINARY}, 1'b1, 160, 1'b1, $urandom, -1);
    send_random_frames(100);
    wait_idle();

    // Stopping the connection can only happen once per reset, so it comes last.
    // Whatever follows is ignored and must produce nothing.
    write_max_payload(17'($urandom_range(200)));
    stop_kind = stop_kind_t'($urandom_range(3));
    stop_hdr  = 8'($urandom);
    case (stop_kind)
      STOP_CLOSE_EMPTY: begin
        send_frame({stop_hdr[7:4], wsd_pkg::OP_CLOSE}, 1'($urandom_range(1)), 0,
                   1'($urandom_range(1)), $urandom, -1);
      end
      STOP_CLOSE_DATA: begin
        send_frame({stop_hdr[7:4], wsd_pkg::OP_CLOSE}, 1'($urandom_range(1)),
                   $urandom_range((payload_cap < 20) ? int'(payload_cap) : 20),
                   1'($urandom_range(1)), $urandom, -1);
      end
      STOP_LEN64: begin
        frames_sent++;
        send_word(stop_hdr);
        send_word({1'($urandom), wsd_pkg::LEN_CODE64});
        repeat (8) send_word(8'($urandom));
      end
      default: begin
        // one byte over the limit; key and payload bytes land after the drop
        send_frame(stop_hdr, 1'($urandom_range(1)), int'(payload_cap) + 1,
                   1'($urandom_range(1)), $urandom, -1);
      end
    endcase
    repeat (20) send_word(8'($urandom));
    wait_idle();

    $display("Checked %0d result words from %0d frames, %0d words sent, limits 0 to 65536.",
             results_checked, frames_sent, words_sent);
    $display("Connection stopped at the end by %s; later words were ignored.",
             stop_kind.name());
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== websocket_frame_deframer_core.f =====
+incdir+rtl
rtl/wsd_pkg.sv
rtl/wsd_front.sv
rtl/wsd_queue.sv
rtl/wsd_back.sv
rtl/websocket_frame_deframer_core.sv
verif/deframer_checker.sv
verif/tb.sv
